[src/event_priority_queue_assert.svh]
// Assertion macros for the event priority queue.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef EVENT_PRIORITY_QUEUE_ASSERT_SVH
`define EVENT_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define EPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define EPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/epq_pkg.sv]
// Shared types and codes for the event priority queue.
// No dependencies; used by the interfaces, the cell and the top level.
package epq_pkg;

  localparam int unsigned REQ_BITS    = 2;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned TAG_BITS    = 8;

  // Request codes; the remaining code is a no-op
  typedef enum logic [REQ_BITS-1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_PEEK = 2'd2
  } req_code_t;

  // Result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Operation broadcast to every cell of the row
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_INS   = 2'd1,
    CELL_SHIFT = 2'd2
  } cell_op_t;

endpackage

[src/epq_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on epq_pkg for the fixed field widths.
interface epq_req_if #(
  parameter int unsigned TIME_BITS = 16,
  parameter int unsigned ID_BITS   = 16
);
  logic                          valid;
  logic                          ready;
  logic [epq_pkg::REQ_BITS-1:0]  req_type;
  logic [TIME_BITS-1:0]          event_time;
  logic                          is_takeoff;
  logic [ID_BITS-1:0]            plane_id;
  logic [epq_pkg::TAG_BITS-1:0]  event_tag;

  modport source (output valid, req_type, event_time, is_takeoff, plane_id, event_tag,
                  input ready);
  modport sink   (input valid, req_type, event_time, is_takeoff, plane_id, event_tag,
                  output ready);
endinterface

interface epq_rsp_if #(
  parameter int unsigned TIME_BITS = 16,
  parameter int unsigned ID_BITS   = 16
);
  logic                            valid;
  logic                            ready;
  logic [epq_pkg::STATUS_BITS-1:0] status;
  logic [TIME_BITS-1:0]            out_time;
  logic                            out_takeoff;
  logic [ID_BITS-1:0]              out_plane_id;
  logic [epq_pkg::TAG_BITS-1:0]    out_tag;
  logic                            now_empty;

  modport source (output valid, status, out_time, out_takeoff, out_plane_id, out_tag,
                  now_empty, input ready);
  modport sink   (input valid, status, out_time, out_takeoff, out_plane_id, out_tag,
                  now_empty, output ready);
endinterface

[src/epq_cell.sv]
// One slot of the sorted shift-register queue.
// Depends on epq_pkg for the cell operation code and the tag width.
module epq_cell #(
  parameter int unsigned ENT_W = 41
) (
  input  logic              clk,
  input  logic              rst_n,
  input  epq_pkg::cell_op_t op,
  input  logic [ENT_W-1:0]  new_entry,
  input  logic [ENT_W-1:0]  left_entry,
  input  logic              left_valid,
  input  logic              left_lt,
  input  logic [ENT_W-1:0]  right_entry,
  input  logic              right_valid,
  output logic [ENT_W-1:0]  entry,
  output logic              valid,
  output logic              lt
);

  localparam int unsigned KEY_LO = epq_pkg::TAG_BITS;

  logic [ENT_W-1:0] entry_r, entry_nxt;
  logic             valid_r, valid_nxt;

  // Stored key ranks strictly ahead of the new key
  assign lt = valid_r && (entry_r[ENT_W-1:KEY_LO] < new_entry[ENT_W-1:KEY_LO]);

  // Keep, take the new entry, or shift from a neighbour
  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    case (op)
      epq_pkg::CELL_INS: begin
        if (lt) begin
          entry_nxt = entry_r;
          valid_nxt = valid_r;
        end else if (left_lt) begin
          entry_nxt = new_entry;
          valid_nxt = 1'b1;
        end else begin
          entry_nxt = left_entry;
          valid_nxt = left_valid;
        end
      end
      epq_pkg::CELL_SHIFT: begin
        entry_nxt = right_entry;
        valid_nxt = right_valid;
      end
      default: begin
        entry_nxt = entry_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

[src/event_priority_queue.sv]
// Top level of the event priority queue: a row of sorting cells and a result register.
// Depends on epq_pkg, epq_if, epq_cell and event_priority_queue_assert.svh.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------------------
//  in_chan  | in  | valid/ready        | req_type, event_time, is_takeoff, plane_id, tag
//  out_chan | out | valid/ready        | status, out_time, out_takeoff, out_plane_id,
//           |     |                    | out_tag, now_empty
//
// All cells compare against the new key in parallel and insert or shift in the same
// edge, so a request may follow in the next cycle if the last result is being taken.
// The result is registered on its transfer and stays until taken; a new request
// is taken while the result register is empty or being drained in that cycle.
// Reset clears the cell valid bits and the result valid flag; entries and result
// fields hold no reset value.
`include "event_priority_queue_assert.svh"

module event_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned TIME_BITS   = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  epq_req_if.sink   in_chan,
  epq_rsp_if.source out_chan
);

  localparam int unsigned TAG_W = epq_pkg::TAG_BITS;
  localparam int unsigned KEY_W = TIME_BITS + 1 + ID_BITS;
  localparam int unsigned ENT_W = KEY_W + TAG_W;

  logic [ENT_W-1:0]       ent   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] vld;
  logic [QUEUE_DEPTH-1:0] lt;
  logic [ENT_W-1:0]       new_entry;
  epq_pkg::cell_op_t      op;
  epq_pkg::req_code_t     req;

  logic fire, full, empty, enq_ok, deq_ok, front_rd;

  logic                           out_valid_r;
  epq_pkg::status_t               status_r, status_nxt;
  logic [ENT_W-1:0]               front_r, front_nxt;
  logic                           now_empty_r, now_empty_nxt;

  // Accept while the result register is free or drains this cycle
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign fire          = in_chan.valid && in_chan.ready;

  assign req       = epq_pkg::req_code_t'(in_chan.req_type);
  assign new_entry = {in_chan.event_time, in_chan.is_takeoff, in_chan.plane_id,
                      in_chan.event_tag};
  assign full      = vld[QUEUE_DEPTH-1];
  assign empty     = !vld[0];
  assign enq_ok    = fire && (req == epq_pkg::REQ_ENQ) && !full;
  assign deq_ok    = fire && (req == epq_pkg::REQ_DEQ) && !empty;
  assign front_rd  = ((req == epq_pkg::REQ_DEQ) || (req == epq_pkg::REQ_PEEK)) && !empty;

  // Broadcast the row operation
  always_comb begin
    if (enq_ok) begin
      op = epq_pkg::CELL_INS;
    end else if (deq_ok) begin
      op = epq_pkg::CELL_SHIFT;
    end else begin
      op = epq_pkg::CELL_HOLD;
    end
  end

  // Row of cells; the front sits in cell 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ENT_W-1:0] l_ent, r_ent;
    logic             l_vld, l_lt, r_vld;

    if (i == 0) begin : g_head
      assign l_ent = '0;
      assign l_vld = 1'b1;
      assign l_lt  = 1'b1;
    end else begin : g_body
      assign l_ent = ent[i-1];
      assign l_vld = vld[i-1];
      assign l_lt  = lt[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_ent = '0;
      assign r_vld = 1'b0;
    end else begin : g_inner
      assign r_ent = ent[i+1];
      assign r_vld = vld[i+1];
    end

    epq_cell #(.ENT_W(ENT_W)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .new_entry   (new_entry),
      .left_entry  (l_ent),
      .left_valid  (l_vld),
      .left_lt     (l_lt),
      .right_entry (r_ent),
      .right_valid (r_vld),
      .entry       (ent[i]),
      .valid       (vld[i]),
      .lt          (lt[i])
    );
  end

  // Form the result of the request being transferred
  always_comb begin
    status_nxt    = epq_pkg::ST_OK;
    front_nxt     = '0;
    now_empty_nxt = empty;
    case (req)
      epq_pkg::REQ_ENQ: begin
        if (full) begin
          status_nxt = epq_pkg::ST_FULL;
        end
        now_empty_nxt = 1'b0;
      end
      epq_pkg::REQ_DEQ: begin
        if (empty) begin
          status_nxt = epq_pkg::ST_EMPTY;
        end else begin
          now_empty_nxt = !vld[1];
        end
      end
      epq_pkg::REQ_PEEK: begin
        if (empty) begin
          status_nxt = epq_pkg::ST_EMPTY;
        end
      end
      default: begin
        status_nxt = epq_pkg::ST_OK;
      end
    endcase
    if (front_rd) begin
      front_nxt = ent[0];
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r    <= status_nxt;
      front_r     <= front_nxt;
      now_empty_r <= now_empty_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = status_r;
  assign out_chan.out_time     = front_r[ENT_W-1 -: TIME_BITS];
  assign out_chan.out_takeoff  = front_r[TAG_W + ID_BITS];
  assign out_chan.out_plane_id = front_r[TAG_W +: ID_BITS];
  assign out_chan.out_tag      = front_r[TAG_W-1:0];
  assign out_chan.now_empty    = now_empty_r;

  // Occupied cells form an unbroken run from the front
  logic [QUEUE_DEPTH-1:0] vld_inc;
  assign vld_inc = vld + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1};

  `EPQ_ASSERT_IMP(a_vld_prefix, 1'b1, (vld & vld_inc) == '0, "cell valid bits not a prefix")
  `EPQ_ASSERT_IMP(a_front_order, vld[1], ent[0][ENT_W-1:TAG_W] <= ent[1][ENT_W-1:TAG_W],
                  "front two entries out of order")
  `EPQ_ASSERT_NXT(a_full_refused, fire && (req == epq_pkg::REQ_ENQ) && full,
                  $stable(vld) && out_valid_r && (status_r == epq_pkg::ST_FULL),
                  "enqueue into full queue not refused")
  `EPQ_ASSERT_NXT(a_deq_shrinks, deq_ok, vld == ($past(vld) >> 1),
                  "dequeue did not remove exactly one entry")

endmodule
